### hdl/sads_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sads_pkg
// Shared types and fixed widths of the distinct substring counter.
// ----------------------------------------------------------------------------
package sads_pkg;

   localparam int SYMBOL_W = 8;
   localparam int COUNT_W  = 20;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                final_symbol;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               too_long;
   } rsp_type;

   typedef enum logic [4:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_EXT_LEN,
      SEQ_EXT_CUR,
      SEQ_WALK,
      SEQ_WALK_LINK,
      SEQ_CHK_P,
      SEQ_CHK_Q,
      SEQ_CLN_LINK,
      SEQ_COPY,
      SEQ_REDIR_RD,
      SEQ_REDIR_CHK,
      SEQ_REDIR_LINK,
      SEQ_FIX_Q,
      SEQ_FIX_CUR,
      SEQ_FIN,
      SEQ_RESULT
   } seq_type;

   typedef struct packed {
      logic start;
      logic final_symbol;
      logic slot_free;
   } core_cmd_type;

   typedef struct packed {
      logic    ready;
      logic    done;
      rsp_type result;
   } core_sts_type;

endpackage

### hdl/sads_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sads_core
// Suffix automaton sequencer: state length, suffix link and transition
// memories driven by one small sequencer with a shared length incrementer.
// ----------------------------------------------------------------------------
module sads_core #(
   parameter int MAX_LEN       = 1024,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  sads_pkg::core_cmd_type             cmd,
   input  logic [$clog2(ALPHABET_SIZE)-1:0]   cmd_symbol,
   output sads_pkg::core_sts_type             sts
);
   import sads_pkg::*;

   localparam int NUM_STATES = 2 * MAX_LEN;
   localparam int SW         = $clog2(NUM_STATES);
   localparam int AW         = $clog2(ALPHABET_SIZE);
   localparam int TAW        = SW + AW;
   localparam int LW         = $clog2(MAX_LEN + 1);
   localparam int KW         = AW + 1;

   // memories
   logic [LW-1:0] len_mem   [1 << SW];
   logic [SW-1:0] link_mem  [1 << SW];
   logic [SW-1:0] trans_mem [1 << TAW];

   logic [LW-1:0]  len_rd_ff;
   logic [SW-1:0]  link_rd_ff;
   logic [SW-1:0]  trans_rd_ff;

   logic           len_we;
   logic [SW-1:0]  len_wa, len_ra;
   logic [LW-1:0]  len_wd;
   logic           link_we;
   logic [SW-1:0]  link_wa, link_ra, link_wd;
   logic           trans_we;
   logic [TAW-1:0] trans_wa, trans_ra;
   logic [SW-1:0]  trans_wd;

   seq_type             seq_ff, seq_in;
   logic [AW-1:0]       c_ff, c_in;
   logic                fin_ff, fin_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       p_ff, p_in;
   logic [SW-1:0]       q_ff, q_in;
   logic [SW-1:0]       cl_ff, cl_in;
   logic [SW-1:0]       count_ff, count_in;
   logic [SW-1:0]       last_ff, last_in;
   logic [LW-1:0]       cur_len_ff, cur_len_in;
   logic [LW-1:0]       len_p1_ff, len_p1_in;
   logic [LW-1:0]       link_len_ff, link_len_in;
   logic [COUNT_W-1:0]  running_ff, running_in;
   logic [LW-1:0]       taken_ff, taken_in;
   logic                ovf_ff, ovf_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [TAW-1:0]      clr_addr_ff, clr_addr_in;
   logic [TAW-1:0]      clr_last_ff, clr_last_in;

   logic [LW-1:0] len_inc;
   logic [KW-1:0] k_dec;
   logic          k_issue;
   logic          has_room;

   assign len_inc  = len_rd_ff + 1'b1;
   assign k_dec    = k_ff - 1'b1;
   assign k_issue  = (k_ff < KW'(ALPHABET_SIZE));
   assign has_room = (taken_ff < LW'(MAX_LEN));

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_wa] <= len_wd;
      end
      len_rd_ff <= len_mem[len_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (trans_we) begin
         trans_mem[trans_wa] <= trans_wd;
      end
      trans_rd_ff <= trans_mem[trans_ra];
   end

   // next state
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_CLEAR:      if (clr_addr_ff == clr_last_ff) seq_in = SEQ_IDLE;
         SEQ_IDLE: begin
            if (cmd.start) begin
               if (has_room) begin
                  seq_in = SEQ_EXT_LEN;
               end else if (cmd.final_symbol) begin
                  seq_in = SEQ_RESULT;
               end
            end
         end
         SEQ_EXT_LEN:    seq_in = SEQ_EXT_CUR;
         SEQ_EXT_CUR:    seq_in = SEQ_WALK;
         SEQ_WALK: begin
            if (trans_rd_ff == '0) begin
               seq_in = (p_ff == '0) ? SEQ_FIN : SEQ_WALK_LINK;
            end else begin
               seq_in = SEQ_CHK_P;
            end
         end
         SEQ_WALK_LINK:  seq_in = SEQ_WALK;
         SEQ_CHK_P:      seq_in = SEQ_CHK_Q;
         SEQ_CHK_Q:      seq_in = (len_p1_ff == len_rd_ff) ? SEQ_FIN : SEQ_CLN_LINK;
         SEQ_CLN_LINK:   seq_in = SEQ_COPY;
         SEQ_COPY:       if (!k_issue) seq_in = SEQ_REDIR_RD;
         SEQ_REDIR_RD:   seq_in = SEQ_REDIR_CHK;
         SEQ_REDIR_CHK: begin
            if (trans_rd_ff == q_ff && p_ff != '0) begin
               seq_in = SEQ_REDIR_LINK;
            end else begin
               seq_in = SEQ_FIX_Q;
            end
         end
         SEQ_REDIR_LINK: seq_in = SEQ_REDIR_CHK;
         SEQ_FIX_Q:      seq_in = SEQ_FIX_CUR;
         SEQ_FIX_CUR:    seq_in = SEQ_FIN;
         SEQ_FIN:        seq_in = fin_ff ? SEQ_RESULT : SEQ_IDLE;
         SEQ_RESULT:     if (cmd.slot_free) seq_in = SEQ_CLEAR;
         default:        seq_in = SEQ_CLEAR;
      endcase
   end

   // datapath registers
   always_comb begin
      c_in        = c_ff;
      fin_in      = fin_ff;
      cur_in      = cur_ff;
      p_in        = p_ff;
      q_in        = q_ff;
      cl_in       = cl_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      cur_len_in  = cur_len_ff;
      len_p1_in   = len_p1_ff;
      link_len_in = link_len_ff;
      running_in  = running_ff;
      taken_in    = taken_ff;
      ovf_in      = ovf_ff;
      k_in        = k_ff;
      clr_addr_in = clr_addr_ff;
      clr_last_in = clr_last_ff;
      case (seq_ff)
         SEQ_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         SEQ_IDLE: begin
            if (cmd.start) begin
               c_in   = cmd_symbol;
               fin_in = cmd.final_symbol;
               if (!has_room) begin
                  ovf_in = 1'b1;
               end
            end
         end
         SEQ_EXT_LEN: begin
            cur_in   = count_ff;
            count_in = count_ff + 1'b1;
            p_in     = last_ff;
         end
         SEQ_EXT_CUR: begin
            cur_len_in = len_inc;
         end
         SEQ_WALK: begin
            if (trans_rd_ff == '0) begin
               link_len_in = '0;
            end else begin
               q_in = trans_rd_ff;
            end
         end
         SEQ_WALK_LINK: begin
            p_in = link_rd_ff;
         end
         SEQ_CHK_P: begin
            len_p1_in = len_inc;
         end
         SEQ_CHK_Q: begin
            if (len_p1_ff == len_rd_ff) begin
               link_len_in = len_rd_ff;
            end else begin
               cl_in       = count_ff;
               count_in    = count_ff + 1'b1;
               link_len_in = len_p1_ff;
               k_in        = '0;
            end
         end
         SEQ_COPY: begin
            k_in = k_ff + 1'b1;
         end
         SEQ_REDIR_LINK: begin
            p_in = link_rd_ff;
         end
         SEQ_FIN: begin
            running_in = running_ff + COUNT_W'(cur_len_ff - link_len_ff);
            last_in    = cur_ff;
            taken_in   = taken_ff + 1'b1;
         end
         SEQ_RESULT: begin
            if (cmd.slot_free) begin
               clr_addr_in = '0;
               clr_last_in = {SW'(count_ff - 1'b1), {AW{1'b1}}};
               count_in    = SW'(1);
               last_in     = '0;
               running_in  = '0;
               taken_in    = '0;
               ovf_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // memory ports and status
   always_comb begin
      len_we   = 1'b0;
      len_wa   = '0;
      len_wd   = '0;
      len_ra   = '0;
      link_we  = 1'b0;
      link_wa  = '0;
      link_wd  = '0;
      link_ra  = '0;
      trans_we = 1'b0;
      trans_wa = '0;
      trans_wd = '0;
      trans_ra = '0;
      sts.ready  = (seq_ff == SEQ_IDLE);
      sts.done   = (seq_ff == SEQ_RESULT) && cmd.slot_free;
      sts.result = '{distinct_count: running_ff, too_long: ovf_ff};
      case (seq_ff)
         SEQ_CLEAR: begin
            trans_we = 1'b1;
            trans_wa = clr_addr_ff;
            // root length stays zero
            len_we   = 1'b1;
         end
         SEQ_EXT_LEN: begin
            len_ra = last_ff;
         end
         SEQ_EXT_CUR: begin
            len_we   = 1'b1;
            len_wa   = cur_ff;
            len_wd   = len_inc;
            trans_ra = {p_ff, c_ff};
         end
         SEQ_WALK: begin
            if (trans_rd_ff == '0) begin
               trans_we = 1'b1;
               trans_wa = {p_ff, c_ff};
               trans_wd = cur_ff;
               if (p_ff == '0) begin
                  link_we = 1'b1;
                  link_wa = cur_ff;
               end else begin
                  link_ra = p_ff;
               end
            end else begin
               len_ra = p_ff;
            end
         end
         SEQ_WALK_LINK: begin
            trans_ra = {link_rd_ff, c_ff};
         end
         SEQ_CHK_P: begin
            len_ra = q_ff;
         end
         SEQ_CHK_Q: begin
            if (len_p1_ff == len_rd_ff) begin
               link_we = 1'b1;
               link_wa = cur_ff;
               link_wd = q_ff;
            end else begin
               len_we  = 1'b1;
               len_wa  = count_ff;
               len_wd  = len_p1_ff;
               link_ra = q_ff;
            end
         end
         SEQ_CLN_LINK: begin
            link_we = 1'b1;
            link_wa = cl_ff;
            link_wd = link_rd_ff;
         end
         SEQ_COPY: begin
            // read slot k of q, write slot k-1 of the clone
            if (k_issue) begin
               trans_ra = {q_ff, k_ff[AW-1:0]};
            end
            if (k_ff != '0) begin
               trans_we = 1'b1;
               trans_wa = {cl_ff, k_dec[AW-1:0]};
               trans_wd = trans_rd_ff;
            end
         end
         SEQ_REDIR_RD: begin
            trans_ra = {p_ff, c_ff};
         end
         SEQ_REDIR_CHK: begin
            if (trans_rd_ff == q_ff) begin
               trans_we = 1'b1;
               trans_wa = {p_ff, c_ff};
               trans_wd = cl_ff;
               link_ra  = p_ff;
            end
         end
         SEQ_REDIR_LINK: begin
            trans_ra = {link_rd_ff, c_ff};
         end
         SEQ_FIX_Q: begin
            link_we = 1'b1;
            link_wa = q_ff;
            link_wd = cl_ff;
         end
         SEQ_FIX_CUR: begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = cl_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= SEQ_CLEAR;
         fin_ff      <= 1'b0;
         count_ff    <= SW'(1);
         last_ff     <= '0;
         running_ff  <= '0;
         taken_ff    <= '0;
         ovf_ff      <= 1'b0;
         k_ff        <= '0;
         clr_addr_ff <= '0;
         clr_last_ff <= '1;
      end else begin
         seq_ff      <= seq_in;
         fin_ff      <= fin_in;
         count_ff    <= count_in;
         last_ff     <= last_in;
         running_ff  <= running_in;
         taken_ff    <= taken_in;
         ovf_ff      <= ovf_in;
         k_ff        <= k_in;
         clr_addr_ff <= clr_addr_in;
         clr_last_ff <= clr_last_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff        <= c_in;
      cur_ff      <= cur_in;
      p_ff        <= p_in;
      q_ff        <= q_in;
      cl_ff       <= cl_in;
      cur_len_ff  <= cur_len_in;
      len_p1_ff   <= len_p1_in;
      link_len_ff <= link_len_in;
   end

endmodule

### hdl/suffix_automaton_distinct_substrings.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_distinct_substrings
// Counts the distinct non-empty substrings of a byte string.
//
// Input channel req_*: one byte per item; final_symbol marks the last byte.
// Result channel rsp_*: one item per string, after its final byte, with the
// substring count and a too-long flag. Bytes past MAX_LEN are dropped.
// Each byte extends an online suffix automaton held in three memories.
// A byte walks suffix links until it finds an existing transition; a clone
// copies the transition row of the state it splits slot by slot, then
// redirects transitions along the suffix links of the walk.
// After a final byte the transition rows in use are cleared before the
// next byte is taken.
// After reset the whole transition memory, 2*MAX_LEN rows rounded up to a
// power of two, is cleared first; req_stall stays high meanwhile.
// The result sits in an output register; while rsp_stall holds it, the
// block still takes bytes and only waits when the next result is ready.
// ----------------------------------------------------------------------------
module suffix_automaton_distinct_substrings #(
   parameter int MAX_LEN       = 1024,
   parameter int ALPHABET_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sads_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sads_pkg::rsp_type rsp_data
);
   import sads_pkg::*;

   localparam int AW    = $clog2(ALPHABET_SIZE);
   localparam int REM_W = 2 * SYMBOL_W;
   localparam logic [REM_W-1:0] ALPHA_REM = REM_W'(ALPHABET_SIZE);

   core_cmd_type cmd;
   core_sts_type sts;

   logic [REM_W-1:0] sym_rem;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   // symbol reduced into the alphabet
   always_comb begin
      sym_rem = {{SYMBOL_W{1'b0}}, req_data.symbol};
      for (int k = SYMBOL_W - 1; k >= 0; k--) begin
         if (sym_rem >= (ALPHA_REM << k)) begin
            sym_rem = sym_rem - (ALPHA_REM << k);
         end
      end
   end

   assign req_stall        = !sts.ready;
   assign cmd.start        = req_valid && sts.ready;
   assign cmd.final_symbol = req_data.final_symbol;
   assign cmd.slot_free    = !rsp_valid_ff || !rsp_stall;

   sads_core #(
      .MAX_LEN       (MAX_LEN),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_symbol (sym_rem[AW-1:0]),
      .sts        (sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (sts.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = sts.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result never overwrites one still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written while output slot held");

   // a result is followed by the clearing sweep
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> (req_stall && rsp_valid))
      else $error("block ready right after a result");

   // clearing starts out of reset
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("input taken during reset clear");

endmodule

### bench/suffix_automaton_distinct_substrings_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_distinct_substrings_tb
// Self-checking bench for the distinct substring counter.
//
// Byte strings go in one item per byte; every final byte must produce one
// result with the distinct substring count and the too-long flag. A
// behavioral suffix automaton in the bench predicts each count. A short
// table of hand-picked strings comes first, then random strings: narrow
// alphabets and periodic patterns that force clones and long link walks,
// wide random bytes, and one string past the length limit. Both sides
// idle at random, and the result side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module suffix_automaton_distinct_substrings_tb;

   localparam int MAX_LEN      = 1024;
   localparam int ALPHABET     = 256;
   localparam int N_STATES     = 2 * MAX_LEN;
   localparam int TOTAL_ITEMS  = 1900;
   localparam int CALM_FROM    = TOTAL_ITEMS - 120;
   localparam int LONG_FROM    = 400;
   localparam int HOLD_AFTER   = 12;
   localparam int LONG_HOLD    = 20000;
   localparam int DRAIN_CYCLES = 1000;
   localparam int N_ROWS       = 21;

   localparam logic [11:0] NO_LINK = '1;

   typedef enum int {NARROW, PERIODIC, WIDE} text_style_type;

   typedef struct packed {
      logic [7:0]  sym;
      logic        last;
      logic        pinned;
      logic [19:0] count;
      logic        over;
   } probe_row_type;

   // hand-picked strings; pinned rows carry the count typed in
   localparam probe_row_type PROBES [N_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, 20'd1, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 20'd1, 1'b0},
      '{8'h61, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h61, 1'b1, 1'b1, 20'd2, 1'b0},
      '{8'h00, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 20'd3, 1'b0},
      // abb: clones a state
      '{8'h61, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h62, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h62, 1'b1, 1'b1, 20'd5, 1'b0},
      '{8'h61, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h62, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h61, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h62, 1'b1, 1'b1, 20'd7, 1'b0},
      '{8'h61, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h61, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h61, 1'b1, 1'b1, 20'd3, 1'b0},
      '{8'hAA, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h55, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'hAA, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'h55, 1'b0, 1'b0, 20'd0, 1'b0},
      '{8'hAA, 1'b1, 1'b0, 20'd0, 1'b0}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   sads_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   sads_pkg::rsp_type rsp_data;

   // bench copy of the automaton
   logic [10:0] sa_len  [N_STATES];
   logic [11:0] sa_link [N_STATES];
   logic [10:0] sa_next [N_STATES][ALPHABET];
   logic [11:0] sa_size;
   logic [10:0] sa_last;
   logic [19:0] substr_total;
   logic [10:0] bytes_in_string;
   logic        string_overflow;

   sads_pkg::rsp_type expected_counts [$];
   sads_pkg::rsp_type count_due;

   int items_sent;
   int results_seen = 0;
   int mismatch_count = 0;
   bit calm;
   bit long_hold_done = 1'b0;

   suffix_automaton_distinct_substrings #(
      .MAX_LEN       (MAX_LEN),
      .ALPHABET_SIZE (ALPHABET)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int link_of(input int s);
      return (sa_link[s] == NO_LINK) ? -1 : int'(sa_link[s]);
   endfunction

   task automatic sa_clear();
      for (int s = 0; s < int'(sa_size); s++)
         for (int a = 0; a < ALPHABET; a++)
            sa_next[s][a] = '0;
      sa_len[0]       = '0;
      sa_link[0]      = NO_LINK;
      sa_size         = 12'd1;
      sa_last         = '0;
      substr_total    = '0;
      bytes_in_string = '0;
      string_overflow = 1'b0;
   endtask

   task automatic sa_extend(input logic [7:0] sym);
      int c;
      int cur;
      int p;
      int q;
      int cl;
      c = int'(sym) % ALPHABET;
      cur = int'(sa_size);
      sa_size = sa_size + 1'b1;
      sa_len[cur] = sa_len[sa_last] + 1'b1;
      p = int'(sa_last);
      while (p >= 0 && sa_next[p][c] == '0) begin
         sa_next[p][c] = 11'(cur);
         p = link_of(p);
      end
      if (p < 0) begin
         sa_link[cur] = '0;
      end else begin
         q = int'(sa_next[p][c]);
         if (int'(sa_len[p]) + 1 == int'(sa_len[q])) begin
            sa_link[cur] = 12'(q);
         end else begin
            // split q: the clone takes the shorter length
            cl = int'(sa_size);
            sa_size = sa_size + 1'b1;
            sa_len[cl] = sa_len[p] + 1'b1;
            for (int a = 0; a < ALPHABET; a++)
               sa_next[cl][a] = sa_next[q][a];
            sa_link[cl] = sa_link[q];
            while (p >= 0 && int'(sa_next[p][c]) == q) begin
               sa_next[p][c] = 11'(cl);
               p = link_of(p);
            end
            sa_link[q]   = 12'(cl);
            sa_link[cur] = 12'(cl);
         end
      end
      substr_total = substr_total + 20'(sa_len[cur] - sa_len[sa_link[cur]]);
      sa_last = 11'(cur);
   endtask

   task automatic absorb_byte(input sads_pkg::req_type item, output bit has_result,
                              output sads_pkg::rsp_type result);
      if (int'(bytes_in_string) < MAX_LEN) begin
         sa_extend(item.symbol);
         bytes_in_string = bytes_in_string + 1'b1;
      end else begin
         string_overflow = 1'b1;
      end
      has_result            = item.final_symbol;
      result.distinct_count = substr_total;
      result.too_long       = string_overflow;
      if (item.final_symbol)
         sa_clear();
   endtask

   // entered and left at a falling edge
   task automatic offer(input sads_pkg::req_type item, input bit pinned,
                        input sads_pkg::rsp_type pinned_rsp);
      int gap;
      bit has_result;
      sads_pkg::rsp_type predicted;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall);
      absorb_byte(item, has_result, predicted);
      if (has_result)
         expected_counts = {expected_counts, (pinned ? pinned_rsp : predicted)};
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_string(input int len, input text_style_type style);
      sads_pkg::req_type item;
      logic [7:0] base;
      logic [7:0] motif [4];
      int width;
      int period;
      base   = 8'($urandom);
      width  = $urandom_range(1, 4);
      period = $urandom_range(1, 4);
      for (int k = 0; k < 4; k++)
         motif[k] = base + 8'($urandom_range(0, width - 1));
      for (int i = 0; i < len; i++) begin
         case (style)
            NARROW:   item.symbol = base + 8'($urandom_range(0, width - 1));
            PERIODIC: begin
               item.symbol = motif[i % period];
               if ($urandom_range(0, 7) == 0)
                  item.symbol = 8'($urandom);
            end
            default:  item.symbol = 8'($urandom);
         endcase
         item.final_symbol = (i == len - 1);
         offer(item, 1'b0, '0);
      end
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
   endtask

   // result side: short random holds, one long hold
   initial begin : rx_side
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end else if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 3);
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_counts.size() == 0) begin
            note_mismatch("unexpected result", -1, int'(rsp_data.distinct_count));
         end else begin
            count_due = expected_counts.pop_front();
            if (rsp_data.distinct_count !== count_due.distinct_count)
               note_mismatch("distinct_count", int'(count_due.distinct_count),
                             int'(rsp_data.distinct_count));
            if (rsp_data.too_long !== count_due.too_long)
               note_mismatch("too_long", int'(count_due.too_long), int'(rsp_data.too_long));
         end
      end
   end

   initial begin : tx_side
      sads_pkg::req_type item;
      sads_pkg::rsp_type pinned_rsp;
      bit long_done;
      int pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      items_sent     = 0;
      calm           = 1'b0;
      long_done      = 1'b0;
      for (int s = 0; s < N_STATES; s++) begin
         sa_len[s]  = '0;
         sa_link[s] = '0;
      end
      sa_size = 12'(N_STATES);
      sa_clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         item.symbol               = PROBES[r].sym;
         item.final_symbol         = PROBES[r].last;
         pinned_rsp.distinct_count = PROBES[r].count;
         pinned_rsp.too_long       = PROBES[r].over;
         offer(item, PROBES[r].pinned, pinned_rsp);
      end

      while (items_sent < TOTAL_ITEMS) begin
         if (!long_done && items_sent >= LONG_FROM) begin
            // runs past the length limit; the final byte's symbol is dropped but still ends the string
            send_string(MAX_LEN + $urandom_range(1, 4), WIDE);
            long_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               send_string(1, WIDE);
            else if (pick <= 4)
               send_string($urandom_range(2, 10), NARROW);
            else if (pick <= 7)
               send_string($urandom_range(2, 12), PERIODIC);
            else
               send_string($urandom_range(2, 8), WIDE);
         end
         if (items_sent >= CALM_FROM)
            calm = 1'b1;
      end
      req_valid = 1'b0;

      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_counts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
hdl/sads_pkg.sv
hdl/sads_core.sv
hdl/suffix_automaton_distinct_substrings.sv
bench/suffix_automaton_distinct_substrings_tb.sv
